// File: rtl/ircs_pkg.sv
// ----------------------------------------------------------------------------
// ircs_pkg
// Types and codes shared by the intercore rendezvous and sync unit.
// ----------------------------------------------------------------------------
package ircs_pkg;

  localparam int TAG_W  = 32;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;
  localparam int PEER_W = 6;
  localparam int EV_W   = 5;
  localparam int TGT_W  = 16;
  localparam int CID_W  = 6;

  // instruction opcodes
  localparam logic [2:0] OP_SEND = 3'd0;
  localparam logic [2:0] OP_RECV = 3'd1;
  localparam logic [2:0] OP_SYNC = 3'd2;
  localparam logic [2:0] OP_WAIT = 3'd3;
  localparam logic [2:0] OP_NOP  = 3'd4;

  // incoming message kinds
  localparam logic [1:0] MSG_SREADY = 2'd0;
  localparam logic [1:0] MSG_RREADY = 2'd1;
  localparam logic [1:0] MSG_SDATA  = 2'd2;
  localparam logic [1:0] MSG_SYNC   = 2'd3;

  localparam logic REQ_INST = 1'b0;

  typedef enum logic [2:0] {
    K_SREADY = 3'd0,
    K_RREADY = 3'd1,
    K_SDATA  = 3'd2,
    K_SYNC   = 3'd3,
    K_MRD    = 3'd4,
    K_MWR    = 3'd5,
    K_COMMIT = 3'd6,
    K_ERR    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2,
    MODE_WAIT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [PEER_W-1:0]   dest;
    logic [TAG_W-1:0]    tag;
    logic [ADDR_W-1:0]   addr;
    logic [SIZE_W-1:0]   size;
    logic [EV_W-1:0]     event_idx;
  } res_t;

  typedef struct packed {
    logic active;
    logic done;
  } emit_stat_t;

  localparam res_t RES_ZERO = '0;

endpackage

// File: rtl/ircs_ram.sv
// ----------------------------------------------------------------------------
// ircs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ircs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ircs_emit.sv
// ----------------------------------------------------------------------------
// ircs_emit
// Result queue: holds up to three results and plays them out one per cycle.
// ----------------------------------------------------------------------------
module ircs_emit
  import ircs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res_in [3],
  input  logic [1:0] res_cnt,
  output res_t       res_out,
  output logic       res_valid,
  output logic       res_last,
  output emit_stat_t stat
);

  res_t       q_r [3];
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  logic       active_r;
  logic       is_last;

  assign is_last   = (idx_r == 2'(cnt_r - 2'd1));
  assign res_out   = q_r[idx_r];
  assign res_valid = active_r;
  assign res_last  = active_r & is_last;
  assign stat      = '{active: active_r, done: active_r & is_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= 2'd0;
      cnt_r    <= 2'd0;
    end else if (load) begin
      active_r <= (res_cnt != 2'd0);
      idx_r    <= 2'd0;
      cnt_r    <= res_cnt;
    end else if (active_r) begin
      idx_r <= idx_r + 2'd1;
      if (is_last) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= res_in;
    end
  end

endmodule

// File: rtl/intercore_rendezvous_sync_unit.sv
// ----------------------------------------------------------------------------
// intercore_rendezvous_sync_unit
// Send/recv rendezvous, remote sync and local wait for one core.
// ----------------------------------------------------------------------------
// One beat is taken at a time: start is honored while busy is low. The cycle
// after acceptance reads the early-sender tag RAM and the event counter RAM
// and updates state; the beat's results then leave on out_valid one per
// cycle, 0 to 3 of them, out_last on the final one. Busy stays high until
// the beat's results, if any, have left, so no new beat is taken before then.
// Results cannot be held off by the receiver. Reset clears the valid bits of
// both RAMs at once; no clearing pass is needed.
module intercore_rendezvous_sync_unit
  import ircs_pkg::*;
#(
  parameter int NUM_CORES      = 64,
  parameter int NUM_EVENT_REGS = 32,
  parameter int COUNTER_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic [2:0]        in_opcode,
  input  logic [1:0]        in_msg_kind,
  input  logic [PEER_W-1:0] in_peer_core,
  input  logic [TAG_W-1:0]  in_inst_tag,
  input  logic [ADDR_W-1:0] in_local_addr,
  input  logic [SIZE_W-1:0] in_data_size,
  input  logic [EV_W-1:0]   in_event_index,
  input  logic [TGT_W-1:0]  in_wait_target,
  input  logic              cfg_we,
  input  logic [CID_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [2:0]        out_kind,
  output logic [PEER_W-1:0] out_dest_core,
  output logic [TAG_W-1:0]  out_tag,
  output logic [ADDR_W-1:0] out_addr,
  output logic [SIZE_W-1:0] out_size,
  output logic [EV_W-1:0]   out_event,
  output logic              out_last
);

  localparam int CIDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int EIDX_W = (NUM_EVENT_REGS > 1) ? $clog2(NUM_EVENT_REGS) : 1;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  logic                    send_ok_r, send_ok_nxt;
  logic [PEER_W-1:0]       send_peer_r, send_peer_nxt;
  logic [TAG_W-1:0]        send_tag_r, send_tag_nxt;
  logic                    recv_ok_r, recv_ok_nxt;
  logic [PEER_W-1:0]       recv_peer_r, recv_peer_nxt;
  logic [ADDR_W-1:0]       pend_addr_r, pend_addr_nxt;
  logic [SIZE_W-1:0]       pend_size_r, pend_size_nxt;
  logic [EV_W-1:0]         wait_idx_r, wait_idx_nxt;
  logic [TGT_W-1:0]        wait_val_r, wait_val_nxt;
  logic [CID_W-1:0]        own_id_r;

  // captured beat
  logic                    x_req_r;
  logic [2:0]              x_op_r;
  logic [1:0]              x_kind_r;
  logic [PEER_W-1:0]       x_peer_r;
  logic [TAG_W-1:0]        x_tag_r;
  logic [ADDR_W-1:0]       x_addr_r;
  logic [SIZE_W-1:0]       x_size_r;
  logic [EV_W-1:0]         x_ev_r;
  logic [TGT_W-1:0]        x_tgt_r;

  logic [NUM_CORES-1:0]      early_ok_r;
  logic [NUM_EVENT_REGS-1:0] ev_vld_r;

  logic                    accept;
  logic [CIDX_W-1:0]       cidx;
  logic [EIDX_W-1:0]       eidx;
  logic                    peer_in, ev_in, from_recv;
  logic [TAG_W-1:0]        tag_rd;
  logic [COUNTER_BITS-1:0] cnt_rd, cnt_cur, cnt_inc;
  logic                    tag_we, cnt_we, early_set, early_clr;
  logic [COUNTER_BITS-1:0] cnt_wdata;

  res_t       res [3];
  logic [1:0] res_n;
  logic       load;
  res_t       res_out;
  emit_stat_t emit_stat;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;
  assign load   = (state_r == ST_EXEC);

  assign cidx      = CIDX_W'(x_peer_r);
  assign eidx      = EIDX_W'(x_ev_r);
  assign peer_in   = (32'(x_peer_r) < NUM_CORES);
  assign ev_in     = (32'(x_ev_r) < NUM_EVENT_REGS);
  assign from_recv = recv_ok_r && (recv_peer_r == x_peer_r);
  assign cnt_cur   = ev_vld_r[eidx] ? cnt_rd : '0;
  assign cnt_inc   = COUNTER_BITS'(cnt_cur + 1'b1);

  ircs_ram #(.WIDTH(TAG_W), .DEPTH(NUM_CORES), .AW(CIDX_W)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (cidx),
    .wdata (x_tag_r),
    .raddr (CIDX_W'(in_peer_core)),
    .rdata (tag_rd)
  );

  ircs_ram #(.WIDTH(COUNTER_BITS), .DEPTH(NUM_EVENT_REGS), .AW(EIDX_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (eidx),
    .wdata (cnt_wdata),
    .raddr (EIDX_W'(in_event_index)),
    .rdata (cnt_rd)
  );

  ircs_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res_in    (res),
    .res_cnt   (res_n),
    .res_out   (res_out),
    .res_valid (out_valid),
    .res_last  (out_last),
    .stat      (emit_stat)
  );

  assign out_kind      = res_out.kind;
  assign out_dest_core = res_out.dest;
  assign out_tag       = res_out.tag;
  assign out_addr      = res_out.addr;
  assign out_size      = res_out.size;
  assign out_event     = res_out.event_idx;

  // next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = (res_n == 2'd0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // read-modify-write of the beat in the exec cycle
  always_comb begin
    mode_nxt      = mode_r;
    send_ok_nxt   = send_ok_r;
    send_peer_nxt = send_peer_r;
    send_tag_nxt  = send_tag_r;
    recv_ok_nxt   = recv_ok_r;
    recv_peer_nxt = recv_peer_r;
    pend_addr_nxt = pend_addr_r;
    pend_size_nxt = pend_size_r;
    wait_idx_nxt  = wait_idx_r;
    wait_val_nxt  = wait_val_r;
    tag_we        = 1'b0;
    cnt_we        = 1'b0;
    cnt_wdata     = cnt_inc;
    early_set     = 1'b0;
    early_clr     = 1'b0;
    res[0]        = RES_ZERO;
    res[1]        = RES_ZERO;
    res[2]        = RES_ZERO;
    res_n         = 2'd0;
    if (state_r == ST_EXEC) begin
      if (x_req_r == REQ_INST) begin
        if (mode_r != MODE_IDLE || x_op_r > OP_NOP ||
            (x_op_r <= OP_SYNC && !peer_in)) begin
          res[0].kind = K_ERR;
          res_n       = 2'd1;
        end else begin
          case (x_op_r)
            OP_SEND: begin
              send_ok_nxt   = 1'b1;
              send_peer_nxt = x_peer_r;
              send_tag_nxt  = x_tag_r;
              pend_addr_nxt = x_addr_r;
              pend_size_nxt = x_size_r;
              mode_nxt      = MODE_SEND;
              res[0].kind   = K_SREADY;
              res[0].dest   = x_peer_r;
              res[0].tag    = x_tag_r;
              res_n         = 2'd1;
            end
            OP_RECV: begin
              recv_ok_nxt   = 1'b1;
              recv_peer_nxt = x_peer_r;
              pend_addr_nxt = x_addr_r;
              pend_size_nxt = x_size_r;
              mode_nxt      = MODE_RECV;
              if (early_ok_r[cidx]) begin
                early_clr   = 1'b1;
                res[0].kind = K_RREADY;
                res[0].dest = x_peer_r;
                res[0].tag  = tag_rd;
                res_n       = 2'd1;
              end
            end
            OP_SYNC: begin
              res[0].kind      = K_SYNC;
              res[0].dest      = x_peer_r;
              res[0].event_idx = x_ev_r;
              res[1].kind      = K_COMMIT;
              res_n            = 2'd2;
            end
            OP_WAIT: begin
              if (!ev_in) begin
                res[0].kind = K_ERR;
                res_n       = 2'd1;
              end else if (32'(cnt_cur) == 32'(x_tgt_r)) begin
                cnt_we      = 1'b1;
                cnt_wdata   = '0;
                res[0].kind = K_COMMIT;
                res_n       = 2'd1;
              end else begin
                wait_idx_nxt = x_ev_r;
                wait_val_nxt = x_tgt_r;
                mode_nxt     = MODE_WAIT;
              end
            end
            default: begin
              res[0].kind = K_COMMIT;
              res_n       = 2'd1;
            end
          endcase
        end
      end else begin
        case (x_kind_r)
          MSG_SREADY, MSG_SDATA: begin
            if (from_recv) begin
              if (x_kind_r == MSG_SREADY) begin
                res[0].kind = K_RREADY;
                res[0].dest = x_peer_r;
                res[0].tag  = x_tag_r;
                res_n       = 2'd1;
              end else begin
                recv_ok_nxt = 1'b0;
                mode_nxt    = MODE_IDLE;
                res[0].kind = K_MWR;
                res[0].addr = pend_addr_r;
                res[0].size = pend_size_r;
                res[1].kind = K_COMMIT;
                res_n       = 2'd2;
              end
            end else if (peer_in) begin
              early_set = 1'b1;
              tag_we    = 1'b1;
            end
          end
          MSG_RREADY: begin
            if (send_ok_r && send_peer_r == x_peer_r && x_tag_r == send_tag_r) begin
              send_ok_nxt = 1'b0;
              mode_nxt    = MODE_IDLE;
              res[0].kind = K_MRD;
              res[0].addr = pend_addr_r;
              res[0].size = pend_size_r;
              res[1].kind = K_SDATA;
              res[1].dest = x_peer_r;
              res[1].tag  = send_tag_r;
              res[1].size = pend_size_r;
              res[2].kind = K_COMMIT;
              res_n       = 2'd3;
            end else begin
              res[0].kind = K_ERR;
              res_n       = 2'd1;
            end
          end
          default: begin
            if (ev_in) begin
              cnt_we = 1'b1;
              if (mode_r == MODE_WAIT && x_ev_r == wait_idx_r &&
                  32'(cnt_inc) == 32'(wait_val_r)) begin
                cnt_wdata   = '0;
                mode_nxt    = MODE_IDLE;
                res[0].kind = K_COMMIT;
                res_n       = 2'd1;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= MODE_IDLE;
      send_ok_r  <= 1'b0;
      recv_ok_r  <= 1'b0;
      early_ok_r <= '0;
      ev_vld_r   <= '0;
      own_id_r   <= '0;
      send_tag_r  <= '0;
      pend_addr_r <= '0;
      pend_size_r <= '0;
      wait_idx_r  <= '0;
      wait_val_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      send_ok_r   <= send_ok_nxt;
      recv_ok_r   <= recv_ok_nxt;
      send_tag_r  <= send_tag_nxt;
      pend_addr_r <= pend_addr_nxt;
      pend_size_r <= pend_size_nxt;
      wait_idx_r  <= wait_idx_nxt;
      wait_val_r  <= wait_val_nxt;
      if (cfg_we) begin
        own_id_r <= cfg_wdata;
      end
      if (early_set) begin
        early_ok_r[cidx] <= 1'b1;
      end
      if (early_clr) begin
        early_ok_r[cidx] <= 1'b0;
      end
      if (cnt_we) begin
        ev_vld_r[eidx] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    send_peer_r <= send_peer_nxt;
    recv_peer_r <= recv_peer_nxt;
    if (accept) begin
      x_req_r  <= in_req_type;
      x_op_r   <= in_opcode;
      x_kind_r <= in_msg_kind;
      x_peer_r <= in_peer_core;
      x_tag_r  <= in_inst_tag;
      x_addr_r <= in_local_addr;
      x_size_r <= in_data_size;
      x_ev_r   <= in_event_index;
      x_tgt_r  <= in_wait_target;
    end
  end

`ifndef SYNTH
  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_EMIT)
    else $error("result strobe outside emit state");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC)
    else $error("accepted beat did not enter exec");

  a_send_mode_peer: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_SEND |-> send_ok_r)
    else $error("send mode without a send peer");

  a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> emit_stat.active)
    else $error("emit state with empty result queue");
`endif

endmodule

// File: bench/intercore_rendezvous_sync_unit_test.sv
// ----------------------------------------------------------------------------
// intercore_rendezvous_sync_unit_test
// Self-checking bench: directed and random instructions and network messages
// go into the unit, and every result strobe is compared against a predictor.
// ----------------------------------------------------------------------------
module intercore_rendezvous_sync_unit_test;
  import ircs_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [5:0]  dest;
    logic [31:0] tag;
    logic [31:0] addr;
    logic [15:0] size;
    logic [4:0]  ev;
    logic        last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = 1'b0;
  logic [2:0] in_opcode = '0;
  logic [1:0] in_msg_kind = '0;
  logic [5:0] in_peer_core = '0;
  logic [31:0] in_inst_tag = '0;
  logic [31:0] in_local_addr = '0;
  logic [15:0] in_data_size = '0;
  logic [4:0] in_event_index = '0;
  logic [15:0] in_wait_target = '0;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;
  logic out_valid;
  logic [2:0] out_kind;
  logic [5:0] out_dest_core;
  logic [31:0] out_tag;
  logic [31:0] out_addr;
  logic [15:0] out_size;
  logic [4:0] out_event;
  logic out_last;

  intercore_rendezvous_sync_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_opcode(in_opcode), .in_msg_kind(in_msg_kind),
    .in_peer_core(in_peer_core), .in_inst_tag(in_inst_tag),
    .in_local_addr(in_local_addr), .in_data_size(in_data_size),
    .in_event_index(in_event_index), .in_wait_target(in_wait_target),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_kind(out_kind), .out_dest_core(out_dest_core),
    .out_tag(out_tag), .out_addr(out_addr), .out_size(out_size),
    .out_event(out_event), .out_last(out_last)
  );

  always #5 clk = ~clk;

  // predictor state
  mode_t       mdl_mode;
  logic        mdl_send_ok, mdl_recv_ok;
  logic [5:0]  mdl_send_peer, mdl_recv_peer;
  logic [31:0] mdl_send_tag, mdl_addr;
  logic [15:0] mdl_size;
  logic        mdl_early_ok [64];
  logic [31:0] mdl_early_tag [64];
  logic [15:0] mdl_cnt [32];
  logic [4:0]  mdl_wait_idx;
  logic [15:0] mdl_wait_val;

  beat_t expected_beats[$];
  int    mismatches = 0;
  int    beats_seen = 0;
  int    items_sent = 0;
  bit    quiet = 0;

  task automatic push_beat(input logic [2:0] k, input logic [5:0] d, input logic [31:0] t,
                           input logic [31:0] a, input logic [15:0] s, input logic [4:0] e);
    beat_t b;
    b.kind = k; b.dest = d; b.tag = t; b.addr = a; b.size = s; b.ev = e; b.last = 1'b0;
    expected_beats.push_back(b);
  endtask

  task automatic predict_rendezvous(input logic rq, input logic [2:0] op,
                                    input logic [1:0] mk, input logic [5:0] pr,
                                    input logic [31:0] tg, input logic [31:0] ad,
                                    input logic [15:0] sz, input logic [4:0] ev,
                                    input logic [15:0] wt);
    int n0;
    n0 = expected_beats.size();
    if (rq == REQ_INST) begin
      if (mdl_mode != MODE_IDLE || op > OP_NOP) begin
        push_beat(K_ERR, 0, 0, 0, 0, 0);
      end else begin
        case (op)
          OP_SEND: begin
            mdl_send_ok = 1; mdl_send_peer = pr; mdl_send_tag = tg;
            mdl_addr = ad; mdl_size = sz; mdl_mode = MODE_SEND;
            push_beat(K_SREADY, pr, tg, 0, 0, 0);
          end
          OP_RECV: begin
            mdl_recv_ok = 1; mdl_recv_peer = pr; mdl_addr = ad; mdl_size = sz;
            mdl_mode = MODE_RECV;
            if (mdl_early_ok[pr]) begin
              mdl_early_ok[pr] = 0;
              push_beat(K_RREADY, pr, mdl_early_tag[pr], 0, 0, 0);
            end
          end
          OP_SYNC: begin
            push_beat(K_SYNC, pr, 0, 0, 0, ev);
            push_beat(K_COMMIT, 0, 0, 0, 0, 0);
          end
          OP_WAIT: begin
            if (mdl_cnt[ev] == wt) begin
              mdl_cnt[ev] = 0;
              push_beat(K_COMMIT, 0, 0, 0, 0, 0);
            end else begin
              mdl_wait_idx = ev; mdl_wait_val = wt; mdl_mode = MODE_WAIT;
            end
          end
          default: push_beat(K_COMMIT, 0, 0, 0, 0, 0);
        endcase
      end
    end else begin
      case (mk)
        MSG_SREADY, MSG_SDATA: begin
          if (mdl_recv_ok && mdl_recv_peer == pr) begin
            if (mk == MSG_SREADY) begin
              push_beat(K_RREADY, pr, tg, 0, 0, 0);
            end else begin
              mdl_recv_ok = 0; mdl_mode = MODE_IDLE;
              push_beat(K_MWR, 0, 0, mdl_addr, mdl_size, 0);
              push_beat(K_COMMIT, 0, 0, 0, 0, 0);
            end
          end else begin
            mdl_early_ok[pr] = 1; mdl_early_tag[pr] = tg;
          end
        end
        MSG_RREADY: begin
          if (mdl_send_ok && mdl_send_peer == pr && tg == mdl_send_tag) begin
            mdl_send_ok = 0; mdl_mode = MODE_IDLE;
            push_beat(K_MRD, 0, 0, mdl_addr, mdl_size, 0);
            push_beat(K_SDATA, pr, mdl_send_tag, 0, mdl_size, 0);
            push_beat(K_COMMIT, 0, 0, 0, 0, 0);
          end else begin
            push_beat(K_ERR, 0, 0, 0, 0, 0);
          end
        end
        default: begin
          mdl_cnt[ev] = mdl_cnt[ev] + 16'd1;
          if (mdl_mode == MODE_WAIT && ev == mdl_wait_idx && mdl_cnt[ev] == mdl_wait_val) begin
            mdl_cnt[ev] = 0; mdl_mode = MODE_IDLE;
            push_beat(K_COMMIT, 0, 0, 0, 0, 0);
          end
        end
      endcase
    end
    if (expected_beats.size() > n0) expected_beats[$].last = 1'b1;
  endtask

  task automatic send_item(input logic rq, input logic [2:0] op, input logic [1:0] mk,
                           input logic [5:0] pr, input logic [31:0] tg,
                           input logic [31:0] ad, input logic [15:0] sz,
                           input logic [4:0] ev, input logic [15:0] wt);
    @(posedge clk);
    if (!quiet && $urandom_range(99) < 15) repeat ($urandom_range(4, 1)) @(posedge clk);
    start <= 1'b1;
    in_req_type <= rq; in_opcode <= op; in_msg_kind <= mk; in_peer_core <= pr;
    in_inst_tag <= tg; in_local_addr <= ad; in_data_size <= sz;
    in_event_index <= ev; in_wait_target <= wt;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_rendezvous(rq, op, mk, pr, tg, ad, sz, ev, wt);
    items_sent++;
    start <= 1'b0;
  endtask

  task automatic inst(input logic [2:0] op, input logic [5:0] pr, input logic [31:0] tg,
                      input logic [4:0] ev, input logic [15:0] wt);
    send_item(REQ_INST, op, 2'($urandom), pr, tg, $urandom, 16'($urandom), ev, wt);
  endtask

  task automatic msg(input logic [1:0] mk, input logic [5:0] pr, input logic [31:0] tg,
                     input logic [4:0] ev);
    send_item(1'b1, 3'($urandom), mk, pr, tg, $urandom, 16'($urandom), ev, 16'($urandom));
  endtask

  task automatic drain_and_config(input logic [5:0] id);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= id;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat kind=%0d", out_kind);
      end else begin
        e = expected_beats.pop_front();
        if (out_kind !== e.kind || out_dest_core !== e.dest || out_tag !== e.tag ||
            out_addr !== e.addr || out_size !== e.size || out_event !== e.ev ||
            out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp k=%0d d=%0d t=%h a=%h s=%h e=%0d l=%0d",
                     e.kind, e.dest, e.tag, e.addr, e.size, e.ev, e.last);
            $display("         got k=%0d d=%0d t=%h a=%h s=%h e=%0d l=%0d",
                     out_kind, out_dest_core, out_tag, out_addr, out_size, out_event,
                     out_last);
          end
        end
      end
    end
  end

  task automatic test_directed();
    inst(OP_NOP, 0, 0, 0, 0);
    inst(3'd5, 0, 0, 0, 0);
    inst(3'd7, 63, '1, 31, '1);
    inst(OP_SYNC, 63, 0, 31, 0);
    inst(OP_WAIT, 0, 0, 0, 0);           // counter already matches
    inst(OP_SEND, 63, 32'hFFFF_FFFF, 0, 0);
    inst(OP_NOP, 0, 0, 0, 0);            // refused while a send is pending
    msg(MSG_RREADY, 62, 32'hFFFF_FFFF, 0); // wrong peer
    msg(MSG_RREADY, 63, 32'h0, 0);       // wrong tag
    msg(MSG_RREADY, 63, 32'hFFFF_FFFF, 0);
    msg(MSG_SREADY, 5, 32'hA5A5_5A5A, 0); // early sender
    inst(OP_RECV, 5, 0, 0, 0);
    msg(MSG_SREADY, 5, 32'h1234, 0);
    msg(MSG_SDATA, 5, 0, 0);
    inst(OP_RECV, 0, 0, 0, 0);           // no early sender
    msg(MSG_SDATA, 0, 0, 0);
    inst(OP_WAIT, 31, 0, 31, 16'd2);
    msg(MSG_SYNC, 0, 0, 30);
    msg(MSG_SYNC, 0, 0, 31);
    msg(MSG_SYNC, 0, 0, 31);
    inst(OP_WAIT, 30, 0, 30, 16'd2);     // released by the next sync
    msg(MSG_SYNC, 0, 0, 30);
    msg(MSG_SDATA, 9, 0, 0);             // early sender via a data beat
  endtask

  task automatic test_counter_wrap();
    // push a counter round by a wait that only releases after a wrap to zero is impossible;
    // instead reach a high target with a run of syncs
    inst(OP_WAIT, 0, 0, 7, 16'd40);
    quiet = 1;
    repeat (40) msg(MSG_SYNC, 6'($urandom), $urandom, 7);
    quiet = 0;
  endtask

  task automatic test_random(input int count);
    int sel;
    logic [5:0] p;
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3 && i < count / 2);
      sel = $urandom_range(99);
      p = 6'($urandom_range(7));
      t = $urandom;
      if (mdl_mode == MODE_WAIT && sel < 60) begin
        msg(MSG_SYNC, 6'($urandom), $urandom,
            $urandom_range(1) ? mdl_wait_idx : 5'($urandom));
      end else if (sel < 25) begin
        inst(OP_SEND, p, t, 0, 0);
        msg(MSG_RREADY, p, ($urandom_range(9) == 0) ? ~t : t, 0);
      end else if (sel < 50) begin
        if ($urandom_range(1)) msg(MSG_SREADY, p, $urandom, 0);
        inst(OP_RECV, p, 0, 0, 0);
        if ($urandom_range(1)) msg(MSG_SREADY, p, $urandom, 0);
        msg(MSG_SDATA, p, $urandom, 0);
      end else if (sel < 65) begin
        inst(OP_WAIT, 0, 0, 5'($urandom_range(3)), 16'($urandom_range(3)));
      end else if (sel < 85) begin
        inst(OP_SYNC, 6'($urandom), 0, 5'($urandom), 0);
      end else begin
        send_item(1'($urandom), 3'($urandom), 2'($urandom), 6'($urandom), $urandom,
                  $urandom, 16'($urandom), 5'($urandom), 16'($urandom));
      end
    end
    quiet = 0;
  endtask

  initial begin
    for (int i = 0; i < 64; i++) begin
      mdl_early_ok[i] = 0; mdl_early_tag[i] = 0;
    end
    for (int i = 0; i < 32; i++) mdl_cnt[i] = 0;
    mdl_mode = MODE_IDLE; mdl_send_ok = 0; mdl_recv_ok = 0;
    mdl_send_peer = 0; mdl_recv_peer = 0; mdl_send_tag = 0;
    mdl_addr = 0; mdl_size = 0; mdl_wait_idx = 0; mdl_wait_val = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    drain_and_config(6'd63);
    test_directed();
    drain_and_config(6'd0);
    test_counter_wrap();
    drain_and_config(6'd21);
    test_random(20);
    drain_and_config(6'd42);
    test_random(20);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d items and %0d result beats over four core id settings",
             items_sent, beats_seen);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("intercore_rendezvous_sync_unit regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("intercore_rendezvous_sync_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("intercore_rendezvous_sync_unit regression: fail");
    $finish;
  end

endmodule
